[hdl/plane_from_three_points_defines.svh]
// Assertion macros for the plane-from-three-points block
`ifndef PLANE_FROM_THREE_POINTS_DEFINES_SVH
`define PLANE_FROM_THREE_POINTS_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle
`define PFTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define PFTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pftp_pkg.sv]
// Shared widths, pipeline stage indices and types for the plane block
`default_nettype none
package pftp_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned EdgeW     = CoordW + 1;
  localparam int unsigned ProdW     = 2 * EdgeW;
  localparam int unsigned CrossW    = ProdW + 1;
  localparam int unsigned AbsW      = CrossW - 1;
  localparam int unsigned TopW      = 7;
  localparam int unsigned NormShift = 30;
  localparam int unsigned MagW      = NormShift + 1;
  localparam int unsigned SqW       = 2 * MagW;
  localparam int unsigned SumW      = 64;
  localparam int unsigned RootW     = 32;
  localparam int unsigned NumW      = MagW + NormShift + 1;
  localparam int unsigned CoefW     = 32;
  localparam int unsigned DProdW    = CoordW + CoefW;
  localparam int unsigned DSumW     = DProdW + 2;
  localparam int unsigned DW        = CoordW + 4;

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned SqrtFirst = 8;
  localparam int unsigned DivInit   = SqrtFirst + SqrtSteps;
  localparam int unsigned CoefStg   = DivInit + DivSteps + 1;
  localparam int unsigned StgN      = CoefStg + 4;

  typedef struct packed {
    logic [2:0][MagW-1:0]   mag;
    logic [2:0]             neg;
    logic                   deg;
    logic [2:0][CoordW-1:0] p1;
  } carry_t;

endpackage
`default_nettype wire

[hdl/pftp_in_if.sv]
// Request channel carrying the three input points
`default_nettype none
interface pftp_in_if;
  logic valid;
  logic ready;
  logic signed [pftp_pkg::CoordW-1:0] p1_x, p1_y, p1_z;
  logic signed [pftp_pkg::CoordW-1:0] p2_x, p2_y, p2_z;
  logic signed [pftp_pkg::CoordW-1:0] p3_x, p3_y, p3_z;
  modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
                  input ready);
  modport sink (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
                output ready);
endinterface
`default_nettype wire

[hdl/pftp_out_if.sv]
// Result channel carrying the plane coefficients
`default_nettype none
interface pftp_out_if;
  logic valid;
  logic ready;
  logic signed [pftp_pkg::CoefW-1:0] coef_a, coef_b, coef_c;
  logic signed [pftp_pkg::DW-1:0]    coef_d;
  logic                              degenerate;
  modport source (output valid, coef_a, coef_b, coef_c, coef_d, degenerate, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, coef_d, degenerate, output ready);
endinterface
`default_nettype wire

[hdl/plane_from_three_points.sv]
// Plane coefficients from three points: pipelined cross product, norm and offset
//
// Takes one request of three Q16.16 points per cycle and returns the unit normal
// (a, b, c) in Q1.30 and the offset d in Q20.16, or all zeros with degenerate set
// when the points are repeated or collinear. The pipeline holds a 32-step square root
// and 32-step dividers, each retiring one bit per stage.
// Throughput is one request per cycle; a stall at the output freezes the whole
// pipeline, so in_i.ready follows out_o.ready whenever a result is waiting.
`default_nettype none
`include "plane_from_three_points_defines.svh"
module plane_from_three_points (
  input  logic clk_i,
  input  logic rst_ni,
  pftp_in_if.sink    in_i,
  pftp_out_if.source out_o
);

  localparam int unsigned N = pftp_pkg::StgN;

  logic         en;
  logic [N-1:0] vld_q;

  assign en = !vld_q[N-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N-2:0], in_i.valid};
    end
  end

  // edges
  logic [2:0][pftp_pkg::CoordW-1:0] p1_q [5];
  logic signed [pftp_pkg::EdgeW-1:0] e_q [3];
  logic signed [pftp_pkg::EdgeW-1:0] f_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q[0] <= {in_i.p1_z, in_i.p1_y, in_i.p1_x};
      e_q[0]  <= $signed({in_i.p2_x[31], in_i.p2_x}) - $signed({in_i.p1_x[31], in_i.p1_x});
      e_q[1]  <= $signed({in_i.p2_y[31], in_i.p2_y}) - $signed({in_i.p1_y[31], in_i.p1_y});
      e_q[2]  <= $signed({in_i.p2_z[31], in_i.p2_z}) - $signed({in_i.p1_z[31], in_i.p1_z});
      f_q[0]  <= $signed({in_i.p3_x[31], in_i.p3_x}) - $signed({in_i.p1_x[31], in_i.p1_x});
      f_q[1]  <= $signed({in_i.p3_y[31], in_i.p3_y}) - $signed({in_i.p1_y[31], in_i.p1_y});
      f_q[2]  <= $signed({in_i.p3_z[31], in_i.p3_z}) - $signed({in_i.p1_z[31], in_i.p1_z});
    end
  end

  // cross product terms
  logic signed [pftp_pkg::ProdW-1:0] pr_q [6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q[1] <= p1_q[0];
      pr_q[0] <= e_q[1] * f_q[2];
      pr_q[1] <= e_q[2] * f_q[1];
      pr_q[2] <= e_q[2] * f_q[0];
      pr_q[3] <= e_q[0] * f_q[2];
      pr_q[4] <= e_q[0] * f_q[1];
      pr_q[5] <= e_q[1] * f_q[0];
    end
  end

  logic signed [pftp_pkg::CrossW-1:0] n_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q[2] <= p1_q[1];
      for (int i = 0; i < 3; i++) begin
        n_q[i] <= pftp_pkg::CrossW'(pr_q[2*i]) - pftp_pkg::CrossW'(pr_q[2*i+1]);
      end
    end
  end

  // magnitudes and signs
  logic [pftp_pkg::AbsW-1:0] am_q [3];
  logic [2:0]                ng_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q[3] <= p1_q[2];
      for (int i = 0; i < 3; i++) begin
        ng_q[i]  <= n_q[i][pftp_pkg::CrossW-1];
        am_q[i]  <= n_q[i][pftp_pkg::CrossW-1] ? pftp_pkg::AbsW'(-n_q[i])
                                               : pftp_pkg::AbsW'(n_q[i]);
      end
    end
  end

  // leading one over the block
  logic [pftp_pkg::AbsW-1:0] am_or;
  logic [pftp_pkg::TopW-1:0] top_d, top_q;
  logic [pftp_pkg::AbsW-1:0] am2_q [3];
  logic [2:0]                ng2_q;
  logic                      deg_q;

  always_comb begin
    am_or = am_q[0] | am_q[1] | am_q[2];
    top_d = '0;
    for (int b = 0; b < int'(pftp_pkg::AbsW); b++) begin
      if (am_or[b]) begin
        top_d = pftp_pkg::TopW'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q[4] <= p1_q[3];
      top_q   <= top_d;
      deg_q   <= (am_or == '0);
      ng2_q   <= ng_q;
      for (int i = 0; i < 3; i++) begin
        am2_q[i] <= am_q[i];
      end
    end
  end

  // block scaling
  pftp_pkg::carry_t c5_d, c5_q;

  always_comb begin
    c5_d     = '0;
    c5_d.neg = ng2_q;
    c5_d.deg = deg_q;
    c5_d.p1  = p1_q[4];
    for (int i = 0; i < 3; i++) begin
      if (top_q > pftp_pkg::TopW'(pftp_pkg::NormShift)) begin
        c5_d.mag[i] = pftp_pkg::MagW'(am2_q[i] >> (top_q - pftp_pkg::TopW'(pftp_pkg::NormShift)));
      end else begin
        c5_d.mag[i] = pftp_pkg::MagW'(am2_q[i] << (pftp_pkg::TopW'(pftp_pkg::NormShift) - top_q));
      end
    end
  end

  // squares and their sum
  pftp_pkg::carry_t          c6_q, c7_q;
  logic [pftp_pkg::SqW-1:0]  sq_q [3];
  logic [pftp_pkg::SumW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c5_q <= c5_d;
      c6_q <= c5_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= c5_q.mag[i] * c5_q.mag[i];
      end
      c7_q  <= c6_q;
      sum_q <= pftp_pkg::SumW'(sq_q[0]) + pftp_pkg::SumW'(sq_q[1]) + pftp_pkg::SumW'(sq_q[2]);
    end
  end

  // square root, one result bit per stage
  logic [pftp_pkg::SumW-1:0] sx_q [pftp_pkg::SqrtSteps];
  logic [pftp_pkg::SumW-1:0] sr_q [pftp_pkg::SqrtSteps];
  pftp_pkg::carry_t          sc_q [pftp_pkg::SqrtSteps];

  for (genvar k = 0; k < int'(pftp_pkg::SqrtSteps); k++) begin : g_sqrt
    localparam logic [pftp_pkg::SumW-1:0] Bit = pftp_pkg::SumW'(1) << (62 - 2 * k);
    logic [pftp_pkg::SumW-1:0] x_in, r_in, trial;

    if (k == 0) begin : g_first
      assign x_in = sum_q;
      assign r_in = '0;
      always_ff @(posedge clk_i) begin
        if (en) begin
          sc_q[k] <= c7_q;
        end
      end
    end else begin : g_next
      assign x_in = sx_q[k-1];
      assign r_in = sr_q[k-1];
      always_ff @(posedge clk_i) begin
        if (en) begin
          sc_q[k] <= sc_q[k-1];
        end
      end
    end

    assign trial = r_in + Bit;

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (x_in >= trial) begin
          sx_q[k] <= x_in - trial;
          sr_q[k] <= (r_in >> 1) + Bit;
        end else begin
          sx_q[k] <= x_in;
          sr_q[k] <= r_in >> 1;
        end
      end
    end
  end

  // three restoring dividers sharing the root as divisor
  localparam int unsigned D = pftp_pkg::DivSteps;
  logic [pftp_pkg::RootW-1:0] dv_q [D+1];
  pftp_pkg::carry_t           dc_q [D+1];
  logic [2:0][pftp_pkg::RootW-1:0] drem_q [D+1];
  logic [2:0][pftp_pkg::RootW-1:0] dlo_q  [D+1];
  logic [2:0][pftp_pkg::CoefW-1:0] dquo_q [D+1];
  logic [pftp_pkg::RootW-1:0]      root;
  logic [pftp_pkg::NumW-1:0]       num [3];

  assign root = sr_q[pftp_pkg::SqrtSteps-1][pftp_pkg::RootW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {sc_q[pftp_pkg::SqrtSteps-1].mag[i], pftp_pkg::NormShift'(0)}
             + pftp_pkg::NumW'(root >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0] <= root;
      dc_q[0] <= sc_q[pftp_pkg::SqrtSteps-1];
      for (int i = 0; i < 3; i++) begin
        drem_q[0][i] <= pftp_pkg::RootW'(num[i][pftp_pkg::NumW-1:pftp_pkg::RootW]);
        dlo_q[0][i]  <= num[i][pftp_pkg::RootW-1:0];
        dquo_q[0][i] <= '0;
      end
    end
  end

  for (genvar k = 1; k <= int'(D); k++) begin : g_div
    logic [pftp_pkg::RootW:0] t [3];
    logic [2:0]               ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {drem_q[k-1][i], dlo_q[k-1][i][pftp_pkg::RootW-1]};
        ge[i] = (t[i] >= {1'b0, dv_q[k-1]});
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k] <= dv_q[k-1];
        dc_q[k] <= dc_q[k-1];
        for (int i = 0; i < 3; i++) begin
          drem_q[k][i] <= ge[i] ? pftp_pkg::RootW'(t[i] - {1'b0, dv_q[k-1]})
                                : t[i][pftp_pkg::RootW-1:0];
          dlo_q[k][i]  <= dlo_q[k-1][i] << 1;
          dquo_q[k][i] <= {dquo_q[k-1][i][pftp_pkg::CoefW-2:0], ge[i]};
        end
      end
    end
  end

  // clamp and sign the coefficients
  localparam logic [pftp_pkg::CoefW-1:0] One = pftp_pkg::CoefW'(1) << pftp_pkg::NormShift;
  logic signed [pftp_pkg::CoefW-1:0]  cf_q [3];
  logic signed [pftp_pkg::CoefW-1:0]  cf2_q [3];
  logic signed [pftp_pkg::CoefW-1:0]  cf3_q [3];
  logic [2:0][pftp_pkg::CoordW-1:0]   cp1_q;
  logic                               cdeg_q, cdeg2_q, cdeg3_q;
  logic [pftp_pkg::CoefW-1:0]         vcl [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vcl[i] = (dquo_q[D][i] > One) ? One : dquo_q[D][i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cp1_q  <= dc_q[D].p1;
      cdeg_q <= dc_q[D].deg;
      for (int i = 0; i < 3; i++) begin
        cf_q[i] <= dc_q[D].neg[i] ? $signed(-vcl[i]) : $signed(vcl[i]);
      end
    end
  end

  // offset products and sum
  logic signed [pftp_pkg::DProdW-1:0] dp_q [3];
  logic signed [pftp_pkg::DSumW-1:0]  ds_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cdeg2_q <= cdeg_q;
      for (int i = 0; i < 3; i++) begin
        cf2_q[i] <= cf_q[i];
        dp_q[i]  <= $signed(cp1_q[i]) * cf_q[i];
      end
      cdeg3_q <= cdeg2_q;
      for (int i = 0; i < 3; i++) begin
        cf3_q[i] <= cf2_q[i];
      end
      ds_q <= pftp_pkg::DSumW'(dp_q[0]) + pftp_pkg::DSumW'(dp_q[1])
            + pftp_pkg::DSumW'(dp_q[2]);
    end
  end

  // round, saturate and drive the output register
  localparam logic [pftp_pkg::DSumW:0] Half = (pftp_pkg::DSumW + 1)'(1) << (pftp_pkg::NormShift - 1);
  localparam logic [pftp_pkg::DSumW-pftp_pkg::NormShift:0] Lim =
    (pftp_pkg::DSumW - pftp_pkg::NormShift + 1)'(1) << (pftp_pkg::DW - 1);
  logic signed [pftp_pkg::DSumW-1:0] sneg;
  logic [pftp_pkg::DSumW-1:0]        dm;
  logic [pftp_pkg::DSumW:0]          rnd;
  logic [pftp_pkg::DSumW-pftp_pkg::NormShift:0] mv;
  logic [pftp_pkg::DW-1:0]           d_d;
  logic signed [pftp_pkg::CoefW-1:0] oa_q, ob_q, oc_q;
  logic signed [pftp_pkg::DW-1:0]    od_q;
  logic                              odeg_q;

  always_comb begin
    sneg = -ds_q;
    dm   = sneg[pftp_pkg::DSumW-1] ? pftp_pkg::DSumW'(-sneg) : pftp_pkg::DSumW'(sneg);
    rnd  = {1'b0, dm} + Half;
    mv   = rnd[pftp_pkg::DSumW:pftp_pkg::NormShift];
    if (sneg[pftp_pkg::DSumW-1]) begin
      if (mv > Lim) begin
        mv = Lim;
      end
      d_d = pftp_pkg::DW'(-mv);
    end else begin
      if (mv > Lim - 1'b1) begin
        mv = Lim - 1'b1;
      end
      d_d = pftp_pkg::DW'(mv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      odeg_q <= cdeg3_q;
      oa_q   <= cdeg3_q ? '0 : cf3_q[0];
      ob_q   <= cdeg3_q ? '0 : cf3_q[1];
      oc_q   <= cdeg3_q ? '0 : cf3_q[2];
      od_q   <= cdeg3_q ? '0 : $signed(d_d);
    end
  end

  assign out_o.valid      = vld_q[N-1];
  assign out_o.coef_a     = oa_q;
  assign out_o.coef_b     = ob_q;
  assign out_o.coef_c     = oc_q;
  assign out_o.coef_d     = od_q;
  assign out_o.degenerate = odeg_q;

  `PFTP_ASSERT_IMP(a_deg_zero, out_o.valid && out_o.degenerate, out_o.coef_a == 0 && out_o.coef_b == 0 && out_o.coef_c == 0 && out_o.coef_d == 0, "degenerate result with non-zero coefficients")
  `PFTP_ASSERT_IMP(a_coef_range, out_o.valid && !out_o.degenerate, out_o.coef_a <= 32'sd1073741824 && out_o.coef_a >= -32'sd1073741824 && out_o.coef_b <= 32'sd1073741824 && out_o.coef_b >= -32'sd1073741824 && out_o.coef_c <= 32'sd1073741824 && out_o.coef_c >= -32'sd1073741824, "normal component out of range")
  `PFTP_ASSERT_NXT(a_root_floor, en && vld_q[pftp_pkg::DivInit-1] && !sc_q[pftp_pkg::SqrtSteps-1].deg && root[pftp_pkg::RootW-1:pftp_pkg::NormShift] == '0, 1'b0, "root of scaled norm below unity")

endmodule
`default_nettype wire

[dv/plane_from_three_points_test.sv]
// Testbench for plane_from_three_points: predicted coefficients checked per request
`timescale 1ns / 1ps
`default_nettype none
module plane_from_three_points_test;

  typedef logic [8:0][pftp_pkg::CoordW-1:0] triangle_t;

  typedef struct {
    logic signed [pftp_pkg::CoefW-1:0] a, b, c;
    logic signed [pftp_pkg::DW-1:0]    d;
    logic                              deg;
  } plane_t;

  localparam int unsigned StallLimit = 6000;
  localparam int unsigned DrainWait  = 120;

  logic clk_i;
  logic rst_ni;

  pftp_in_if  req_if ();
  pftp_out_if res_if ();

  plane_from_three_points dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if.sink),
    .out_o  (res_if.source)
  );

  plane_t      planes_due[$];
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_flat;
  int unsigned idle_cycles;
  int unsigned sink_hold_req;
  bit          sender_idles;
  bit          sink_idles;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // exact cross product, block scaling, integer root and rounded divisions
  function automatic plane_t fit_plane(triangle_t t);
    logic signed [127:0] p[3];
    logic signed [127:0] e[3];
    logic signed [127:0] f[3];
    logic signed [127:0] n[3];
    logic signed [127:0] s;
    logic [127:0]        m[3];
    logic [127:0]        dm;
    logic [63:0]         mag[3];
    logic [63:0]         cf[3];
    logic [63:0]         sum, rem, q, bitv, v, mv, dv, lim;
    logic                neg_d;
    int                  top;
    plane_t              r;
    for (int i = 0; i < 3; i++) begin
      p[i] = {{96{t[i][31]}}, t[i]};
      e[i] = {{96{t[3+i][31]}}, t[3+i]} - p[i];
      f[i] = {{96{t[6+i][31]}}, t[6+i]} - p[i];
    end
    n[0] = e[1] * f[2] - e[2] * f[1];
    n[1] = e[2] * f[0] - e[0] * f[2];
    n[2] = e[0] * f[1] - e[1] * f[0];
    top = -1;
    for (int i = 0; i < 3; i++) begin
      m[i] = n[i][127] ? -n[i] : n[i];
      for (int b = 0; b < 128; b++) if (m[i][b] && b > top) top = b;
    end
    if (top < 0) begin
      r.a = '0; r.b = '0; r.c = '0; r.d = '0; r.deg = 1'b1;
      return r;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (top > 30) mag[i] = 64'(m[i] >> (top - 30));
      else mag[i] = 64'(m[i] << (30 - top));
      sum += mag[i] * mag[i];
    end
    rem = sum;
    q = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= q + bitv) begin
        rem -= q + bitv;
        q = (q >> 1) + bitv;
      end else begin
        q >>= 1;
      end
      bitv >>= 2;
    end
    for (int i = 0; i < 3; i++) begin
      v = ((mag[i] << 30) + (q >> 1)) / q;
      if (v > (64'd1 << 30)) v = 64'd1 << 30;
      cf[i] = n[i][127] ? -v : v;
    end
    s = 0;
    for (int i = 0; i < 3; i++) s += p[i] * {{64{cf[i][63]}}, cf[i]};
    s = -s;
    neg_d = s[127];
    dm = (neg_d ? -s : s) + (128'd1 << 29);
    if ((dm >> 93) != 0) mv = '1;
    else mv = 64'(dm >> 30);
    lim = 64'd1 << 35;
    if (neg_d) begin
      if (mv > lim) mv = lim;
      dv = -mv;
    end else begin
      if (mv > lim - 1) mv = lim - 1;
      dv = mv;
    end
    r.a = cf[0][31:0];
    r.b = cf[1][31:0];
    r.c = cf[2][31:0];
    r.d = dv[35:0];
    r.deg = 1'b0;
    return r;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s at result %0d: got %h, want %h", field, n_checked, got, want);
    n_errors++;
  endtask

  task automatic send_request(triangle_t t);
    int unsigned gap;
    gap = 0;
    if (sender_idles && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      @(negedge clk_i);
      req_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid = 1'b1;
    {req_if.p3_z, req_if.p3_y, req_if.p3_x, req_if.p2_z, req_if.p2_y, req_if.p2_x,
     req_if.p1_z, req_if.p1_y, req_if.p1_x} = t;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    planes_due.push_back(fit_plane(t));
    n_sent++;
  endtask

  function automatic logic [31:0] pick_coord(int unsigned span);
    case (span)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2047)) - 1024) <<< 16;
      2: return 32'($signed($urandom_range(0, 131071)) - 65536);
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                           : 32'h8000_0000 + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t t;
    int unsigned kind, span;
    logic signed [31:0] k;
    kind = $urandom_range(0, 19);
    span = $urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 3);
    for (int i = 0; i < 9; i++) t[i] = pick_coord(span);
    if (kind == 0) begin
      for (int i = 0; i < 3; i++) t[3+i] = t[i];
    end else if (kind == 1) begin
      for (int i = 0; i < 3; i++) t[6+i] = t[3+i];
    end else if (kind == 2) begin
      k = $signed($urandom_range(0, 6)) - 3;
      for (int i = 0; i < 3; i++) begin
        t[i] = pick_coord(2);
        t[3+i] = t[i] + 32'($signed($urandom_range(0, 4095)) - 2048);
        t[6+i] = t[i] + k * (t[3+i] - t[i]);
      end
    end
    return t;
  endfunction

  always @(negedge clk_i) begin
    if (sink_hold_req > 0) begin
      res_if.ready = 1'b0;
      sink_hold_req--;
    end else if (idle_cycles > 0) begin
      res_if.ready = 1'b0;
      idle_cycles--;
    end else if (sink_idles && $urandom_range(0, 4) == 0) begin
      res_if.ready = 1'b0;
      idle_cycles = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    end else begin
      res_if.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    plane_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (planes_due.size() == 0) begin
        report("unexpected result", 64'(res_if.coef_a), 64'(0));
      end else begin
        want = planes_due.pop_front();
        if (res_if.coef_a !== want.a) report("coef_a", 64'(res_if.coef_a), 64'(want.a));
        if (res_if.coef_b !== want.b) report("coef_b", 64'(res_if.coef_b), 64'(want.b));
        if (res_if.coef_c !== want.c) report("coef_c", 64'(res_if.coef_c), 64'(want.c));
        if (res_if.coef_d !== want.d) report("coef_d", 64'(res_if.coef_d), 64'(want.d));
        if (res_if.degenerate !== want.deg)
          report("degenerate", 64'(res_if.degenerate), 64'(want.deg));
        if (want.deg) n_flat++;
      end
      n_checked++;
    end
  end

  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (rst_ni && quiet_cycles >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("plane_from_three_points verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    triangle_t t;
    // flat in z, tilted, axis planes, extremes, repeated and collinear points
    send_request('0);
    send_request({32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                  32'h0, 32'h0, 32'h0});
    send_request({32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
                  32'h0, 32'h0, 32'h0});
    send_request({32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0,
                  32'h0, 32'h0, 32'h0});
    send_request({32'h0005_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                  32'h0003_0000, 32'h0002_0000, 32'h0004_0000, 32'h0001_0000,
                  32'h0007_0000});
    send_request({32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000});
    send_request({32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff});
    send_request({32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff});
    send_request({32'h0, 32'h0, 32'h1, 32'h0, 32'h1, 32'h0, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000});
    send_request({32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff});
    send_request({9{32'h1234_5678}});
    send_request({32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 32'h0002_0000,
                  32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                  32'h0001_0000});
    send_request({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0});
    send_request({32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 32'h0,
                  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 9; j++) t[j] = pick_coord(3);
      send_request(t);
    end
  endtask

  task automatic test_random(int unsigned count);
    repeat (count) send_request(random_triangle());
  endtask

  task automatic test_back_to_back();
    sender_idles = 1'b0;
    sink_idles = 1'b0;
    test_random(200);
    sender_idles = 1'b1;
    sink_idles = 1'b1;
  endtask

  task automatic test_output_hold();
    sender_idles = 1'b0;
    sink_hold_req = 400;
    test_random(150);
    sender_idles = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    {req_if.p1_x, req_if.p1_y, req_if.p1_z} = '0;
    {req_if.p2_x, req_if.p2_y, req_if.p2_z} = '0;
    {req_if.p3_x, req_if.p3_y, req_if.p3_z} = '0;
    res_if.ready = 1'b0;
    n_errors = 0; n_sent = 0; n_checked = 0; n_flat = 0;
    idle_cycles = 0; sink_hold_req = 0; quiet_cycles = 0;
    sender_idles = 1'b1;
    sink_idles = 1'b1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(600);
    test_back_to_back();
    test_output_hold();
    test_random(480);
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (planes_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    $display("%0d requests sent, %0d results checked, %0d degenerate", n_sent, n_checked,
             n_flat);
    $display("covered extremes, repeated and collinear points, back-to-back and long hold");
    if (n_errors == 0) begin
      $display("plane_from_three_points verification clean");
    end else begin
      $display("plane_from_three_points verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
